// ===== rtl/first_fit_heap_allocator_macros.svh =====
// assertion macros for the first-fit heap allocator
// needs i_clk and i_rst_n in the module that uses them
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// checked only while out of reset
`define FFHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define FFHA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
// shared types, codes and helpers of the first-fit heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;

    localparam int POOL_WORDS = 1024;
    localparam int AW         = $clog2(POOL_WORDS);
    localparam int SW         = AW + 1;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_SIZE  = 2'd2,
        K_INFO  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_ZERO = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] request_bytes;
        logic [9:0]  handle;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_handle;
        logic [12:0] block_bytes;
        logic [9:0]  free_count;
        logic [12:0] free_bytes;
        logic [12:0] biggest_free_bytes;
        logic [9:0]  used_count;
        logic [12:0] total_bytes;
        logic [6:0]  fill_pct;
        logic [6:0]  scatter_pct;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [16:0] dividend;
        logic [10:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [6:0] quotient;
    } t_div_rsp;

    function automatic logic [16:0] f_mul100(input logic [10:0] x);
        logic [16:0] v;
        v = {6'd0, x};
        return (v << 6) + (v << 5) + (v << 2);
    endfunction

    function automatic logic [11:0] f_next(input logic [9:0] w, input logic [10:0] s);
        return {2'd0, w} + 12'd1 + {1'b0, s};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ffha_div.sv =====
// restoring divider, one quotient bit per cycle, quotients below 128
// depends on ffha_pkg
`default_nettype none
module ffha_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ffha_pkg::t_div_req i_req,
    output ffha_pkg::t_div_rsp     o_rsp
);
    import ffha_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [16:0] r_rem;
    logic [10:0] r_den;
    logic [6:0]  r_q;
    logic [17:0] w_trial;
    logic        w_ge;

    assign w_trial = {7'd0, r_den} << r_cnt;
    assign w_ge    = {1'b0, r_rem} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd6;
                r_rem  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_q    <= '0;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem        <= r_rem - w_trial[16:0];
                    r_q[r_cnt]   <= 1'b1;
                end
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 3'd1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// first-fit heap allocator with forward coalescing, top level
// depends on ffha_pkg, ffha_div and first_fit_heap_allocator_macros.svh
//
// usage
//   command channel: raise start with i_req; the beat is taken when start is
//   high and busy is low. busy stays high until the result is ready.
//   result channel: o_strobe marks o_res for exactly one cycle; it cannot be
//   held off. one result per command.
//   config channel: i_cfg_valid/o_cfg_ready carry pool_words (saturated to
//   2..1024), ready only while idle with start low; a write re-forms the pool
//   as one free block and goes busy in S_INIT to rewrite the first header.
// sequencing
//   the header store is a 1024 x 12 memory with a registered read; each
//   header visited passes through a read state and an evaluate state (S_RD, S_EV).
//   allocate: walks to the first fit; a split writes the new header in S_WR2.
//   free: walks to the block, merges each free block that follows, then writes its header.
//   size query: walks the headers to find the block.
//   info query: walks every header, then divides for fill and, if free words remain, scatter.
//   zero-byte allocate and handle 0 (free, size) answer straight from idle without going busy.
// reset
//   synchronous; after reset S_INIT writes the first header, then the
//   pool is one free block of 1023 words.
`default_nettype none
module first_fit_heap_allocator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ffha_pkg::t_request i_req,
    output logic                    o_strobe,
    output ffha_pkg::t_result       o_res,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [10:0]        i_cfg_data
);
    import ffha_pkg::*;
`include "first_fit_heap_allocator_macros.svh"

    typedef enum logic [10:0] {
        S_INIT = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_RD   = 11'b00000000100,
        S_EV   = 11'b00000001000,
        S_WR2  = 11'b00000010000,
        S_MNX  = 11'b00000100000,
        S_MWR  = 11'b00001000000,
        S_DS1  = 11'b00010000000,
        S_DW1  = 11'b00100000000,
        S_DS2  = 11'b01000000000,
        S_DW2  = 11'b10000000000
    } t_state;

    t_state      r_state;
    logic [10:0] r_pool;
    t_kind       r_kind;
    logic [11:0] r_need;
    logic [9:0]  r_handle;
    logic [9:0]  r_w;
    logic [9:0]  r_hw;
    logic        r_merge;
    logic [10:0] r_size;
    logic [9:0]  r_split;
    logic [10:0] r_splitsz;
    logic [9:0]  r_fcnt;
    logic [9:0]  r_ucnt;
    logic [10:0] r_fw;
    logic [10:0] r_big;
    logic [6:0]  r_upct;
    logic [11:0] r_rdata;
    logic        r_strobe;
    t_result     r_res;

    logic [11:0] mem [POOL_WORDS];

    logic        w_wr;
    logic [9:0]  w_waddr;
    logic [11:0] w_wdata;
    logic        w_used;
    logic [10:0] w_s;
    logic [11:0] w_nxt;
    logic        w_nxt_ok;
    logic [11:0] w_mnxt;
    logic        w_mnxt_ok;
    logic        w_fit;
    logic [10:0] w_take;
    logic [10:0] w_pool_sat;
    logic        w_cfg;
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;

    assign w_used    = r_rdata[0];
    assign w_s       = r_rdata[11:1];
    assign w_nxt     = f_next(r_w, w_s);
    assign w_nxt_ok  = ({1'b0, w_nxt} + 13'd1) < {2'd0, r_pool};
    assign w_mnxt    = f_next(r_hw, r_size);
    assign w_mnxt_ok = ({1'b0, w_mnxt} + 13'd1) < {2'd0, r_pool};
    assign w_fit     = !w_used && ({1'b0, w_s} >= r_need);
    assign w_take    = ({1'b0, w_s} == r_need + 12'd1) ? w_s : r_need[10:0];

    assign w_pool_sat = (i_cfg_data < 11'd2) ? 11'd2
                      : (i_cfg_data > 11'(POOL_WORDS)) ? 11'(POOL_WORDS) : i_cfg_data;
    assign w_cfg      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        w_wr    = 1'b0;
        w_waddr = r_w;
        w_wdata = {w_take, 1'b1};
        unique case (r_state)
            S_INIT: begin
                w_wr    = 1'b1;
                w_waddr = '0;
                w_wdata = {r_pool - 11'd1, 1'b0};
            end
            S_EV: begin
                w_wr = (r_kind == K_ALLOC) && w_fit;
            end
            S_WR2: begin
                w_wr    = 1'b1;
                w_waddr = r_split;
                w_wdata = {r_splitsz, 1'b0};
            end
            S_MWR: begin
                w_wr    = 1'b1;
                w_waddr = r_hw;
                w_wdata = {r_size, 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_RD) begin
            r_rdata <= mem[r_w];
        end
    end

    always_comb begin
        w_div_req.start    = (r_state == S_DS1) || (r_state == S_DS2);
        w_div_req.dividend = (r_state == S_DS1) ? f_mul100(r_fw) : f_mul100(r_big);
        w_div_req.divisor  = (r_state == S_DS1) ? r_pool : r_fw;
    end

    ffha_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_pool   <= 11'(POOL_WORDS);
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_cfg) begin
                        r_pool  <= w_pool_sat;
                        r_state <= S_INIT;
                    end else if (start) begin
                        r_kind   <= t_kind'(i_req.kind);
                        r_need   <= 12'(({1'b0, i_req.request_bytes} + 14'd3) >> 2);
                        r_handle <= i_req.handle;
                        r_w      <= '0;
                        r_merge  <= 1'b0;
                        r_fcnt   <= '0;
                        r_ucnt   <= '0;
                        r_fw     <= '0;
                        r_big    <= '0;
                        r_res    <= '0;
                        if (t_kind'(i_req.kind) == K_ALLOC && i_req.request_bytes == '0) begin
                            r_res.status <= ST_ZERO;
                            r_strobe     <= 1'b1;
                        end else if (t_kind'(i_req.kind) != K_ALLOC
                                     && t_kind'(i_req.kind) != K_INFO
                                     && i_req.handle == '0) begin
                            r_strobe <= 1'b1;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    case (r_kind)
                        K_ALLOC: begin
                            if (w_fit) begin
                                r_res.block_handle <= r_w + 10'd1;
                                r_split   <= 10'(r_w + 10'd1 + w_take[9:0]);
                                r_splitsz <= w_s - w_take - 11'd1;
                                if (w_take != w_s) begin
                                    r_state <= S_WR2;
                                end else begin
                                    r_strobe <= 1'b1;
                                    r_state  <= S_IDLE;
                                end
                            end else if (w_nxt_ok) begin
                                r_w     <= w_nxt[9:0];
                                r_state <= S_RD;
                            end else begin
                                r_res.status <= ST_FAIL;
                                r_strobe     <= 1'b1;
                                r_state      <= S_IDLE;
                            end
                        end
                        K_INFO: begin
                            if (!w_used) begin
                                r_fcnt <= r_fcnt + 10'd1;
                                r_fw   <= r_fw + w_s;
                                if (w_s > r_big) begin
                                    r_big <= w_s;
                                end
                            end else begin
                                r_ucnt <= r_ucnt + 10'd1;
                            end
                            if (w_nxt_ok) begin
                                r_w     <= w_nxt[9:0];
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_DS1;
                            end
                        end
                        default: begin
                            if (r_merge) begin
                                if (!w_used) begin
                                    r_size  <= r_size + w_s + 11'd1;
                                    r_state <= S_MNX;
                                end else begin
                                    r_state <= S_MWR;
                                end
                            end else if ({1'b0, r_w} + 11'd1 == {1'b0, r_handle}) begin
                                if (r_kind == K_SIZE) begin
                                    r_res.block_bytes <= {w_s[10:0], 2'b00};
                                    r_strobe          <= 1'b1;
                                    r_state           <= S_IDLE;
                                end else begin
                                    r_hw    <= r_w;
                                    r_size  <= w_s;
                                    r_merge <= 1'b1;
                                    r_state <= S_MNX;
                                end
                            end else if (w_nxt_ok) begin
                                r_w     <= w_nxt[9:0];
                                r_state <= S_RD;
                            end else begin
                                r_strobe <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_WR2: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_MNX: begin
                    if (w_mnxt_ok) begin
                        r_w     <= w_mnxt[9:0];
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_MWR;
                    end
                end
                S_MWR: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_DS1: begin
                    r_state <= S_DW1;
                end
                S_DW1: begin
                    if (w_div_rsp.done) begin
                        r_upct <= 7'd100 - w_div_rsp.quotient;
                        if (r_fw == '0) begin
                            r_res.free_count         <= r_fcnt;
                            r_res.free_bytes         <= {r_fw, 2'b00};
                            r_res.biggest_free_bytes <= {r_big, 2'b00};
                            r_res.used_count         <= r_ucnt;
                            r_res.total_bytes        <= {r_pool, 2'b00};
                            r_res.fill_pct           <= 7'd100 - w_div_rsp.quotient;
                            r_res.scatter_pct        <= '0;
                            r_strobe                 <= 1'b1;
                            r_state                  <= S_IDLE;
                        end else begin
                            r_state <= S_DS2;
                        end
                    end
                end
                S_DS2: begin
                    r_state <= S_DW2;
                end
                S_DW2: begin
                    if (w_div_rsp.done) begin
                        r_res.free_count         <= r_fcnt;
                        r_res.free_bytes         <= {r_fw, 2'b00};
                        r_res.biggest_free_bytes <= {r_big, 2'b00};
                        r_res.used_count         <= r_ucnt;
                        r_res.total_bytes        <= {r_pool, 2'b00};
                        r_res.fill_pct           <= r_upct;
                        r_res.scatter_pct        <= 7'd100 - w_div_rsp.quotient;
                        r_strobe                 <= 1'b1;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_strobe    = r_strobe;
    assign o_res       = r_res;

    // a result beat always lands with the sequencer back in idle
    `FFHA_ASSERT(a_strobe_idle, o_strobe |-> !busy, "result beat while busy")
    // an accepted command either answers at once or goes busy
    `FFHA_ASSERT(a_start_acts, (start && !busy) |=> (busy || o_strobe), "command dropped")
    // a pool write always rewrites the first header
    `FFHA_ASSERT(a_cfg_reform, w_cfg |=> (r_state == S_INIT), "pool write not re-formed")
    // percentages never exceed one hundred
    `FFHA_ASSERT_ALWAYS(a_pct_range, o_strobe |-> (o_res.fill_pct <= 7'd100 && o_res.scatter_pct <= 7'd100), "percentage out of range")

endmodule
`default_nettype wire

// ===== tb/sv/first_fit_heap_allocator_test.sv =====
// testbench for first_fit_heap_allocator: allocate, free, size and info commands
// checked against a behavioral heap predictor; depends on ffha_pkg and the rtl
`default_nettype none
module first_fit_heap_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int LIMIT = 10000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_request    i_req;
    logic        o_strobe;
    t_result     o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;

    first_fit_heap_allocator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_strobe(o_strobe), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    logic [11:0] heap_hdr [POOL_WORDS];
    int unsigned pool_len;
    t_result     expected_q[$];
    int          errors;
    int          cycles;
    int          n_results;
    int          n_cmds;
    logic [9:0]  live_handles[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (expected_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_res.status !== e.status) report("status", o_res.status, e.status);
                if (o_res.block_handle !== e.block_handle)
                    report("block_handle", o_res.block_handle, e.block_handle);
                if (o_res.block_bytes !== e.block_bytes)
                    report("block_bytes", o_res.block_bytes, e.block_bytes);
                if (o_res.free_count !== e.free_count)
                    report("free_count", o_res.free_count, e.free_count);
                if (o_res.free_bytes !== e.free_bytes)
                    report("free_bytes", o_res.free_bytes, e.free_bytes);
                if (o_res.biggest_free_bytes !== e.biggest_free_bytes)
                    report("biggest_free_bytes", o_res.biggest_free_bytes,
                           e.biggest_free_bytes);
                if (o_res.used_count !== e.used_count)
                    report("used_count", o_res.used_count, e.used_count);
                if (o_res.total_bytes !== e.total_bytes)
                    report("total_bytes", o_res.total_bytes, e.total_bytes);
                if (o_res.fill_pct !== e.fill_pct) report("fill_pct", o_res.fill_pct, e.fill_pct);
                if (o_res.scatter_pct !== e.scatter_pct)
                    report("scatter_pct", o_res.scatter_pct, e.scatter_pct);
            end
        end
    end

    function automatic int unsigned blk_size(input int unsigned w);
        return heap_hdr[w] >> 1;
    endfunction

    function automatic bit walk_next(input int unsigned w, output int unsigned nw);
        int unsigned n;
        n = w + 1 + blk_size(w);
        nw = n;
        return !(n + 1 >= pool_len || n >= POOL_WORDS);
    endfunction

    function automatic bit locate_block(input int unsigned h, output int unsigned hw);
        int unsigned w;
        int unsigned nw;
        w = 0;
        hw = 0;
        if (h == 0) return 0;
        forever begin
            if (w + 1 == h) begin
                hw = w;
                return 1;
            end
            if (!walk_next(w, nw)) return 0;
            w = nw;
        end
    endfunction

    function automatic void reform_pool(input logic [10:0] v);
        int unsigned p;
        p = v;
        if (p < 2) p = 2;
        if (p > POOL_WORDS) p = POOL_WORDS;
        pool_len = p;
        foreach (heap_hdr[i]) heap_hdr[i] = '0;
        heap_hdr[0] = 12'((p - 1) << 1);
    endfunction

    function automatic t_result predict_heap(input t_request rq);
        t_result r;
        int unsigned w, nw, need, s, take;
        int unsigned fcnt, ucnt, fw, big, fb, bb, tb;
        r = '0;
        case (t_kind'(rq.kind))
            K_ALLOC: begin
                if (rq.request_bytes == 0) begin
                    r.status = ST_ZERO;
                    return r;
                end
                need = (rq.request_bytes + 3) >> 2;
                w = 0;
                forever begin
                    s = blk_size(w);
                    if (!heap_hdr[w][0] && s >= need) begin
                        take = (s == need + 1) ? s : need;
                        if (take != s) heap_hdr[w + 1 + take] = 12'((s - take - 1) << 1);
                        heap_hdr[w] = 12'((take << 1) | 1);
                        r.block_handle = 10'(w + 1);
                        r.status = ST_DONE;
                        return r;
                    end
                    if (!walk_next(w, nw)) break;
                    w = nw;
                end
                r.status = ST_FAIL;
            end
            K_FREE: begin
                if (locate_block(rq.handle, w)) begin
                    heap_hdr[w][0] = 1'b0;
                    while (walk_next(w, nw) && !heap_hdr[nw][0])
                        heap_hdr[w] = 12'((blk_size(w) + blk_size(nw) + 1) << 1);
                end
            end
            K_SIZE: begin
                if (locate_block(rq.handle, w)) r.block_bytes = 13'(blk_size(w) * 4);
            end
            default: begin
                fcnt = 0; ucnt = 0; fw = 0; big = 0;
                w = 0;
                forever begin
                    if (!heap_hdr[w][0]) begin
                        fcnt++;
                        fw += blk_size(w);
                        if (blk_size(w) > big) big = blk_size(w);
                    end else begin
                        ucnt++;
                    end
                    if (!walk_next(w, nw)) break;
                    w = nw;
                end
                fb = fw * 4; bb = big * 4; tb = pool_len * 4;
                r.free_count = 10'(fcnt);
                r.free_bytes = 13'(fb);
                r.biggest_free_bytes = 13'(bb);
                r.used_count = 10'(ucnt);
                r.total_bytes = 13'(tb);
                r.fill_pct = 7'(100 - (100 * fb) / tb);
                r.scatter_pct = (fb == 0) ? 7'd0 : 7'(100 - (100 * bb) / fb);
            end
        endcase
        return r;
    endfunction

    task automatic idle_gap();
        int k;
        int n;
        k = $urandom_range(0, 99);
        n = 0;
        if (k < 55) n = 0;
        else if (k < 93) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 40);
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(input t_kind k, input logic [12:0] bytes, input logic [9:0] h);
        t_request rq;
        t_result  r;
        rq.kind = k;
        rq.request_bytes = bytes;
        rq.handle = h;
        i_req <= rq;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        r = predict_heap(rq);
        expected_q.push_back(r);
        n_cmds++;
        if (k == K_ALLOC && r.status == ST_DONE) live_handles.push_back(r.block_handle);
        idle_gap();
    endtask

    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_pool(input logic [10:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reform_pool(v);
        live_handles.delete();
        repeat (2) @(posedge i_clk);
    endtask

    task automatic free_pick();
        int i;
        if (live_handles.size() == 0) return;
        i = $urandom_range(0, live_handles.size() - 1);
        send_cmd(K_FREE, 13'($urandom), live_handles[i]);
        live_handles.delete(i);
    endtask

    task automatic test_directed();
        send_cmd(K_INFO, 0, 0);
        send_cmd(K_ALLOC, 0, 0);
        send_cmd(K_ALLOC, 1, 10'h3ff);
        send_cmd(K_ALLOC, 13'd4096, 0);
        send_cmd(K_ALLOC, 13'h1fff, 0);
        send_cmd(K_ALLOC, 13'd8, 0);
        send_cmd(K_SIZE, 0, 1);
        send_cmd(K_SIZE, 0, 0);
        send_cmd(K_SIZE, 0, 10'h3ff);
        send_cmd(K_FREE, 0, 0);
        send_cmd(K_FREE, 0, 5);
        send_cmd(K_FREE, 0, 1);
        send_cmd(K_FREE, 0, 1);
        send_cmd(K_INFO, 0, 0);
        send_cmd(K_ALLOC, 13'd4084, 0);
        send_cmd(K_ALLOC, 13'd4, 0);
        send_cmd(K_INFO, 0, 0);
        send_cmd(K_FREE, 0, 1);
        send_cmd(K_INFO, 0, 0);
    endtask

    task automatic test_small_pools();
        write_pool(11'd0);
        send_cmd(K_INFO, 0, 0);
        send_cmd(K_ALLOC, 13'd4, 0);
        send_cmd(K_ALLOC, 13'd4, 0);
        send_cmd(K_INFO, 0, 0);
        write_pool(11'h7ff);
        send_cmd(K_INFO, 0, 0);
        write_pool(11'd3);
        send_cmd(K_ALLOC, 13'd4, 0);
        send_cmd(K_INFO, 0, 0);
        write_pool(11'd1);
        send_cmd(K_INFO, 0, 0);
    endtask

    task automatic test_random_heap(input int n, input logic [10:0] pool, input int maxb);
        int k;
        write_pool(pool);
        repeat (n) begin
            k = $urandom_range(0, 99);
            if (k < 45) send_cmd(K_ALLOC, 13'($urandom_range(1, maxb)), 10'($urandom));
            else if (k < 75) free_pick();
            else if (k < 83) begin
                if (live_handles.size() != 0)
                    send_cmd(K_SIZE, 0, live_handles[$urandom_range(0, live_handles.size()-1)]);
            end else if (k < 90) send_cmd(K_INFO, 13'($urandom), 10'($urandom));
            else if (k < 93) send_cmd(K_ALLOC, 0, 10'($urandom));
            else send_cmd(t_kind'($urandom_range(0, 3)), 13'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        errors = 0; cycles = 0; n_results = 0; n_cmds = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        reform_pool(11'd1024);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);
        test_directed();
        test_small_pools();
        test_random_heap(600, 11'd1024, 400);
        test_random_heap(300, 11'd64, 60);
        test_random_heap(300, 11'd200, 4096);
        test_random_heap(400, 11'd1024, 64);
        drain();
        $display("sent %0d commands over pool sizes 2 to 1024, checked %0d results",
                 n_cmds, n_results);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d errors, %0d results missing", errors, expected_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
